### hw/rtl/tlp_pkg.sv
// ----------------------------------------------------------------------------
// tlp_pkg - shared types and helpers for the touch line parser
// Parse phases, the result record and character class helpers.
// ----------------------------------------------------------------------------
package tlp_pkg;

	localparam int unsigned ByteW  = 8;
	localparam int unsigned WordW  = 32;
	localparam int unsigned AccW   = WordW + 4;
	localparam int unsigned TagLen = 5;
	localparam int unsigned TagPosW = 3;

	localparam logic [ByteW-1:0] MaxLenReset = 8'd128;
	localparam logic [ByteW-1:0] ChNewline   = 8'd10;
	localparam logic [ByteW-1:0] ChCr        = 8'd13;
	localparam logic [ByteW-1:0] ChPlus      = 8'h2B;
	localparam logic [ByteW-1:0] ChMinus     = 8'h2D;

	localparam logic [AccW-1:0] ZoneLimPos  = 36'h0_7FFF_FFFF;
	localparam logic [AccW-1:0] ZoneLimNeg  = 36'h0_8000_0000;
	localparam logic [WordW-1:0] StampSat   = 32'hFFFF_FFFF;

	typedef enum logic [3:0] {
		PH_TAG_WS     = 4'd0,
		PH_TAG        = 4'd1,
		PH_ZONE_WS    = 4'd2,
		PH_ZONE_SIGN  = 4'd3,
		PH_ZONE_DIG   = 4'd4,
		PH_STAMP_WS   = 4'd5,
		PH_STAMP_SIGN = 4'd6,
		PH_STAMP_DIG  = 4'd7,
		PH_STAMP_DONE = 4'd8,
		PH_DEAD       = 4'd9
	} phase_t;

	// One parsed line, as handed from the parser core to the output stage
	typedef struct packed {
		logic             hit;
		logic [WordW-1:0] zone;
		logic [WordW-1:0] millis;
	} result_t;

	function automatic logic is_space(input logic [ByteW-1:0] c);
		return (c == 8'd32) || (c == 8'd9) || (c == 8'd11) || (c == 8'd12) || (c == ChCr);
	endfunction

	function automatic logic is_digit(input logic [ByteW-1:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	// Expected tag letter at a given position of "TOUCH"
	function automatic logic [ByteW-1:0] tag_char(input logic [TagPosW-1:0] pos);
		logic [ByteW-1:0] ch;
		unique case (pos)
			3'd0:    ch = 8'h54;
			3'd1:    ch = 8'h4F;
			3'd2:    ch = 8'h55;
			3'd3:    ch = 8'h43;
			3'd4:    ch = 8'h48;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

endpackage

### hw/rtl/tlp_parse_core.sv
// ----------------------------------------------------------------------------
// tlp_parse_core - per-byte parser state and line result
// Updates the parse state on every accepted byte and flags a finished line.
// ----------------------------------------------------------------------------
module tlp_parse_core
	import tlp_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             acc,
	input  logic [ByteW-1:0] rx_byte,
	input  logic [ByteW-1:0] max_len,
	output result_t          res
);

	phase_t             phase_q, phase_n;
	logic [ByteW-1:0]   len_q, len_n;
	logic [TagPosW-1:0] pos_q, pos_n, pos_e;
	logic               mis_q, mis_n, mis_e;
	logic [WordW-1:0]   zval_q, zval_n;
	logic               zneg_q, zneg_n, zov_q, zov_n;
	logic [WordW-1:0]   sval_q, sval_n;
	logic               sneg_q, sneg_n, sov_q, sov_n;

	logic               nl, sp, dg, sgn, stamp_start;
	logic [3:0]         dval;
	logic [AccW-1:0]    zacc, sacc, zlim;
	logic               line_ok;

	// Character classes and digit accumulators
	always_comb begin
		nl   = (rx_byte == ChNewline);
		sp   = is_space(rx_byte);
		dg   = is_digit(rx_byte);
		sgn  = (rx_byte == ChPlus) || (rx_byte == ChMinus);
		dval = rx_byte[3:0];
		zacc = {1'b0, zval_q, 3'b000} + {3'b000, zval_q, 1'b0} + {{(AccW-4){1'b0}}, dval};
		sacc = {1'b0, sval_q, 3'b000} + {3'b000, sval_q, 1'b0} + {{(AccW-4){1'b0}}, dval};
		zlim = zneg_q ? ZoneLimNeg : ZoneLimPos;
		pos_e = (phase_q == PH_TAG) ? pos_q : '0;
		mis_e = (phase_q == PH_TAG) ? mis_q : 1'b0;
	end

	// Next state
	always_comb begin
		phase_n = phase_q;
		len_n   = len_q;
		pos_n   = pos_q;
		mis_n   = mis_q;
		zval_n  = zval_q;
		zneg_n  = zneg_q;
		zov_n   = zov_q;
		sval_n  = sval_q;
		sneg_n  = sneg_q;
		sov_n   = sov_q;
		stamp_start = 1'b0;

		if (acc) begin
			if (nl || (len_q >= max_len)) begin
				// end of line or runaway line: start over
				phase_n = PH_TAG_WS;
				len_n   = '0;
				pos_n   = '0;
				mis_n   = 1'b0;
				zval_n  = '0;
				zneg_n  = 1'b0;
				zov_n   = 1'b0;
				sval_n  = '0;
				sneg_n  = 1'b0;
				sov_n   = 1'b0;
			end else begin
				len_n = len_q + 8'd1;
				unique case (phase_q)
					PH_TAG_WS, PH_TAG: begin
						if (!(phase_q == PH_TAG_WS && sp)) begin
							phase_n = PH_TAG;
							pos_n   = pos_e;
							mis_n   = mis_e;
							if (sp) begin
								phase_n = (!mis_e && pos_e == TagPosW'(TagLen)) ?
									PH_ZONE_WS : PH_DEAD;
							end else if (pos_e < TagPosW'(TagLen) &&
									rx_byte == tag_char(pos_e)) begin
								pos_n = pos_e + 3'd1;
							end else begin
								mis_n = 1'b1;
							end
						end
					end
					PH_ZONE_WS: begin
						if (!sp) begin
							if (sgn) begin
								zneg_n  = (rx_byte == ChMinus);
								phase_n = PH_ZONE_SIGN;
							end else if (dg) begin
								zval_n  = {{(WordW-4){1'b0}}, dval};
								phase_n = PH_ZONE_DIG;
							end else begin
								phase_n = PH_DEAD;
							end
						end
					end
					PH_ZONE_SIGN: begin
						if (dg) begin
							zval_n  = {{(WordW-4){1'b0}}, dval};
							phase_n = PH_ZONE_DIG;
						end else begin
							phase_n = PH_DEAD;
						end
					end
					PH_ZONE_DIG: begin
						if (dg) begin
							if (!zov_q) begin
								if (zacc > zlim) zov_n = 1'b1;
								else zval_n = zacc[WordW-1:0];
							end
						end else if (zov_q) begin
							phase_n = PH_DEAD;
						end else begin
							stamp_start = 1'b1;
						end
					end
					PH_STAMP_WS: begin
						stamp_start = 1'b1;
					end
					PH_STAMP_SIGN: begin
						if (dg) begin
							sval_n  = {{(WordW-4){1'b0}}, dval};
							phase_n = PH_STAMP_DIG;
						end else begin
							sneg_n  = 1'b0;
							sval_n  = '0;
							phase_n = PH_STAMP_DONE;
						end
					end
					PH_STAMP_DIG: begin
						if (dg) begin
							if (!sov_q) begin
								if (sacc[AccW-1:WordW] != '0) sov_n = 1'b1;
								else sval_n = sacc[WordW-1:0];
							end
						end else begin
							phase_n = PH_STAMP_DONE;
						end
					end
					default: begin
					end
				endcase

				// first character of the stamp field
				if (stamp_start) begin
					if (sp) begin
						phase_n = PH_STAMP_WS;
					end else if (sgn) begin
						sneg_n  = (rx_byte == ChMinus);
						phase_n = PH_STAMP_SIGN;
					end else if (dg) begin
						sval_n  = {{(WordW-4){1'b0}}, dval};
						phase_n = PH_STAMP_DIG;
					end else begin
						phase_n = PH_STAMP_DONE;
					end
				end
			end
		end
	end

	// Line result on a newline
	always_comb begin
		line_ok = (phase_q == PH_ZONE_DIG && !zov_q) || (phase_q == PH_STAMP_WS) ||
			(phase_q == PH_STAMP_SIGN) || (phase_q == PH_STAMP_DIG) ||
			(phase_q == PH_STAMP_DONE);
		res.hit  = acc && nl && line_ok;
		res.zone = zneg_q ? (WordW'(0) - zval_q) : zval_q;
		if (phase_q == PH_ZONE_DIG || phase_q == PH_STAMP_SIGN) res.millis = '0;
		else if (sov_q) res.millis = StampSat;
		else res.millis = sneg_q ? (WordW'(0) - sval_q) : sval_q;
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TAG_WS;
			len_q   <= '0;
			pos_q   <= '0;
			mis_q   <= 1'b0;
			zneg_q  <= 1'b0;
			zov_q   <= 1'b0;
			sneg_q  <= 1'b0;
			sov_q   <= 1'b0;
			zval_q  <= '0;
			sval_q  <= '0;
		end else begin
			phase_q <= phase_n;
			len_q   <= len_n;
			pos_q   <= pos_n;
			mis_q   <= mis_n;
			zneg_q  <= zneg_n;
			zov_q   <= zov_n;
			sneg_q  <= sneg_n;
			sov_q   <= sov_n;
			zval_q  <= zval_n;
			sval_q  <= sval_n;
		end
	end

`ifndef SYNTHESIS
	a_nl_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && nl) |=> (phase_q == PH_TAG_WS && len_q == '0))
		else $error("newline did not return parser to line start");
	a_tag_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(pos_q <= TagPosW'(TagLen)))
		else $error("tag position ran past the tag");
	a_runaway_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && !nl && (len_q >= max_len)) |=> (phase_q == PH_TAG_WS && len_q == '0))
		else $error("runaway line did not restart the parser");
`endif

endmodule

### hw/rtl/touch_line_parser.sv
// ----------------------------------------------------------------------------
// touch_line_parser - "TOUCH <zone> [<stamp>]" line recognizer
// Takes one serial byte per request and emits zone and stamp per valid line.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while in_stall is low; each byte updates the parser state directly.
// A line result is registered into the output entry and shown on out_valid, or parked in the skid if the output stalls.
// A two-entry output stage (register plus skid) raises in_stall only when
// both entries hold results that are not yet taken.
// Reset: arst_n clears the parser to line start and max line length to 128.
module touch_line_parser
	import tlp_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [ByteW-1:0]        rx_byte,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [WordW-1:0] zone,
	output logic [WordW-1:0]        device_millis,
	input  logic                    cfg_we,
	input  logic [ByteW-1:0]        cfg_wdata
);

	logic             in_acc, out_pop;
	logic [ByteW-1:0] max_len_q;
	result_t          res;
	logic             out_valid_q, skid_valid_q;
	logic [WordW-1:0] out_zone_q, out_millis_q, skid_zone_q, skid_millis_q;

	assign in_acc   = in_valid && !in_stall;
	assign in_stall = skid_valid_q;
	assign out_pop  = out_valid_q && !out_stall;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MaxLenReset;
		end else if (cfg_we) begin
			max_len_q <= cfg_wdata;
		end
	end

	tlp_parse_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.acc     (in_acc),
		.rx_byte (rx_byte),
		.max_len (max_len_q),
		.res     (res)
	);

	// Output register and skid: hold a result while the sink stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (skid_valid_q) begin
				if (out_pop) skid_valid_q <= 1'b0;
			end else if (res.hit) begin
				if (out_valid_q && out_stall) skid_valid_q <= 1'b1;
				else out_valid_q <= 1'b1;
			end else if (out_pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload of the two entries
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_pop) begin
				out_zone_q   <= skid_zone_q;
				out_millis_q <= skid_millis_q;
			end
		end else if (res.hit) begin
			if (out_valid_q && out_stall) begin
				skid_zone_q   <= res.zone;
				skid_millis_q <= res.millis;
			end else begin
				out_zone_q   <= res.zone;
				out_millis_q <= res.millis;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign zone          = $signed(out_zone_q);
	assign device_millis = out_millis_q;

`ifndef SYNTHESIS
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry held without an output entry");
	a_hit_to_skid: assert property (@(posedge clk) disable iff (!arst_n)
		(res.hit && out_valid_q && out_stall) |=> skid_valid_q)
		else $error("result arriving at a stalled output was not parked");
	a_skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_valid_q && !out_stall) |=> (!skid_valid_q && out_valid_q))
		else $error("skid entry did not move to the output");
`endif

endmodule
